/* rtl/bns_pkg.sv */
// Package for box non-maximum suppression.
// Holds field widths, payload structs, register map and sequencer states.
// No dependencies.
package bns_pkg;

	localparam int COORD_BITS      = 12;
	localparam int MAX_BOXES_DEF   = 64;
	localparam int LIMIT_W         = 17;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd19661;

	localparam logic [0:0] REG_OVERLAP_LIMIT = 1'b0;

	typedef struct packed {
		logic [COORD_BITS-1:0] box_x;
		logic [COORD_BITS-1:0] box_y;
		logic [COORD_BITS-1:0] box_width;
		logic [COORD_BITS-1:0] box_height;
		logic                  is_last_box;
	} box_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] kept_x;
		logic [COORD_BITS-1:0] kept_y;
		logic [COORD_BITS-1:0] kept_width;
		logic [COORD_BITS-1:0] kept_height;
		logic                  is_last_kept;
		logic                  set_overflowed;
	} box_out_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} rect_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_AR,
		ST_FIND_END,
		ST_SUP_RD,
		ST_SUP_SPAN,
		ST_SUP_INT,
		ST_SUP_AREA,
		ST_SUP_UNI,
		ST_SUP_PLO,
		ST_SUP_PHI,
		ST_SUP_CMP
	} state_t;

endpackage

/* rtl/bns_cfg_regs.sv */
// APB register block for box non-maximum suppression.
// Holds the overlap limit register with readback. Depends on bns_pkg.
module bns_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bns_pkg::APB_AW-1:0]      paddr,
	input  logic [bns_pkg::APB_DW-1:0]      pwdata,
	output logic [bns_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	output logic [bns_pkg::LIMIT_W-1:0]     overlap_limit
);

	logic [bns_pkg::LIMIT_W-1:0] limit_q;
	logic                        hit;

	assign hit   = (paddr[bns_pkg::APB_AW-1] == bns_pkg::REG_OVERLAP_LIMIT);
	assign pready = 1'b1;
	assign overlap_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bns_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			limit_q <= pwdata[bns_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(bns_pkg::APB_DW-bns_pkg::LIMIT_W){1'b0}}, limit_q};
		end
	end

endmodule

/* rtl/box_nonmax_suppression.sv */
// Box non-maximum suppression: stores a set of boxes, then greedily keeps
// boxes by area and drops those whose IoU with a kept box reaches the limit.
// Load: one box per cycle, busy low. After the last box, each round scans the
// live boxes to pick the largest, then runs an IoU test on each live box
// through one shared 17x17 multiplier. Each kept box is a one-cycle strobe;
// the receiver cannot stall. Reset empties the set.
module box_nonmax_suppression #(
	parameter int MAX_BOXES = bns_pkg::MAX_BOXES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bns_pkg::box_in_t                box_in,
	output logic                            result_valid,
	output bns_pkg::box_out_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bns_pkg::APB_AW-1:0]      paddr,
	input  logic [bns_pkg::APB_DW-1:0]      pwdata,
	output logic [bns_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);

	localparam int C  = bns_pkg::COORD_BITS;
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int AW = 2 * C;
	localparam int MW = bns_pkg::LIMIT_W;
	localparam int PW = 2 * MW;
	localparam int KW = PW + MW + 1;

	logic [MW-1:0]         limit;
	bns_pkg::state_t       state_q, state_d;

	bns_pkg::rect_t        box_store [MAX_BOXES];
	bns_pkg::rect_t        rdata_q;
	bns_pkg::rect_t        best_q, pend_q;
	logic [CW-1:0]         count_q, n_q, idx_q, n_next;
	logic [IW-1:0]         best_idx_q;
	logic                  ovf_q, found_q, held_q;
	logic [MAX_BOXES-1:0]  alive_q;
	logic [AW-1:0]         best_area_q, inter_q, area_q;
	logic [C-1:0]          ow_q, oh_q, cw_q, ch_q;
	logic [PW-1:0]         uni_q, plo_q, phi_q;

	logic                  load, room, at_end, cur_alive, emit, emit_last;
	logic [MW-1:0]         mul_a, mul_b;
	logic [PW-1:0]         mul_p;
	logic [C-1:0]          ow_c, oh_c;
	logic [KW-1:0]         lhs, rhs;

	bns_cfg_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.overlap_limit (limit)
	);

	function automatic logic [C-1:0] span(input logic [C-1:0] a0, input logic [C-1:0] al,
		input logic [C-1:0] b0, input logic [C-1:0] bl);
		logic [C:0] lo, ae, be, hi, d;
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		ae = {1'b0, a0} + {1'b0, al};
		be = {1'b0, b0} + {1'b0, bl};
		hi = (ae < be) ? ae : be;
		d  = (hi > lo) ? (hi - lo) : '0;
		return d[C-1:0];
	endfunction

	assign room      = (count_q < CW'(MAX_BOXES));
	assign load      = start && !busy;
	assign n_next    = room ? (count_q + CW'(1)) : count_q;
	assign at_end    = (idx_q == n_q);
	assign cur_alive = alive_q[idx_q[IW-1:0]];
	assign ow_c      = span(best_q.x, best_q.w, rdata_q.x, rdata_q.w);
	assign oh_c      = span(best_q.y, best_q.h, rdata_q.y, rdata_q.h);
	assign mul_p     = mul_a * mul_b;
	assign lhs       = KW'({inter_q, 16'b0});
	assign rhs       = KW'({phi_q, 17'b0}) + KW'(plo_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bns_pkg::ST_IDLE: begin
				if (load && box_in.is_last_box) state_d = bns_pkg::ST_FIND_RD;
			end
			bns_pkg::ST_FIND_RD: begin
				if (at_end) state_d = bns_pkg::ST_FIND_END;
				else if (cur_alive) state_d = bns_pkg::ST_FIND_AR;
			end
			bns_pkg::ST_FIND_AR:  state_d = bns_pkg::ST_FIND_RD;
			bns_pkg::ST_FIND_END: state_d = found_q ? bns_pkg::ST_SUP_RD : bns_pkg::ST_IDLE;
			bns_pkg::ST_SUP_RD: begin
				if (at_end) state_d = bns_pkg::ST_FIND_RD;
				else if (cur_alive) state_d = bns_pkg::ST_SUP_SPAN;
			end
			bns_pkg::ST_SUP_SPAN: state_d = bns_pkg::ST_SUP_INT;
			bns_pkg::ST_SUP_INT:  state_d = bns_pkg::ST_SUP_AREA;
			bns_pkg::ST_SUP_AREA: state_d = bns_pkg::ST_SUP_UNI;
			bns_pkg::ST_SUP_UNI:  state_d = bns_pkg::ST_SUP_PLO;
			bns_pkg::ST_SUP_PLO:  state_d = bns_pkg::ST_SUP_PHI;
			bns_pkg::ST_SUP_PHI:  state_d = bns_pkg::ST_SUP_CMP;
			bns_pkg::ST_SUP_CMP:  state_d = bns_pkg::ST_SUP_RD;
			default:              state_d = bns_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != bns_pkg::ST_IDLE);
		emit      = 1'b0;
		emit_last = 1'b0;
		mul_a     = MW'(rdata_q.w);
		mul_b     = MW'(rdata_q.h);
		case (state_q)
			bns_pkg::ST_FIND_END: begin
				emit      = !found_q || held_q;
				emit_last = !found_q;
			end
			bns_pkg::ST_SUP_INT: begin
				mul_a = MW'(ow_q);
				mul_b = MW'(oh_q);
			end
			bns_pkg::ST_SUP_AREA: begin
				mul_a = MW'(cw_q);
				mul_b = MW'(ch_q);
			end
			bns_pkg::ST_SUP_PLO: begin
				mul_a = limit;
				mul_b = uni_q[MW-1:0];
			end
			bns_pkg::ST_SUP_PHI: begin
				mul_a = limit;
				mul_b = uni_q[PW-1:MW];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load && room) begin
			box_store[count_q[IW-1:0]] <= '{x: box_in.box_x, y: box_in.box_y,
				w: box_in.box_width, h: box_in.box_height};
		end
		rdata_q <= box_store[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bns_pkg::ST_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			n_q          <= '0;
			found_q      <= 1'b0;
			held_q       <= 1'b0;
			alive_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			case (state_q)
				bns_pkg::ST_IDLE: begin
					if (load) begin
						if (room) count_q <= n_next;
						else ovf_q <= 1'b1;
						if (box_in.is_last_box) begin
							n_q     <= n_next;
							idx_q   <= '0;
							found_q <= 1'b0;
							held_q  <= 1'b0;
							for (int i = 0; i < MAX_BOXES; i++) begin
								alive_q[i] <= (CW'(i) < n_next);
							end
						end
					end
				end
				bns_pkg::ST_FIND_RD: begin
					if (!at_end && !cur_alive) idx_q <= idx_q + CW'(1);
				end
				bns_pkg::ST_FIND_AR: begin
					if (!found_q || (mul_p[AW-1:0] > best_area_q)) found_q <= 1'b1;
					idx_q <= idx_q + CW'(1);
				end
				bns_pkg::ST_FIND_END: begin
					if (found_q) begin
						alive_q[best_idx_q] <= 1'b0;
						held_q              <= 1'b1;
					end else begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					idx_q <= '0;
				end
				bns_pkg::ST_SUP_RD: begin
					if (at_end) begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end else if (!cur_alive) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				bns_pkg::ST_SUP_CMP: begin
					if (lhs >= rhs) alive_q[idx_q[IW-1:0]] <= 1'b0;
					idx_q <= idx_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bns_pkg::ST_FIND_AR: begin
				if (!found_q || (mul_p[AW-1:0] > best_area_q)) begin
					best_q      <= rdata_q;
					best_area_q <= mul_p[AW-1:0];
					best_idx_q  <= idx_q[IW-1:0];
				end
			end
			bns_pkg::ST_FIND_END: begin
				if (found_q) pend_q <= best_q;
			end
			bns_pkg::ST_SUP_SPAN: begin
				ow_q <= ow_c;
				oh_q <= oh_c;
				cw_q <= rdata_q.w;
				ch_q <= rdata_q.h;
			end
			bns_pkg::ST_SUP_INT:  inter_q <= mul_p[AW-1:0];
			bns_pkg::ST_SUP_AREA: area_q  <= mul_p[AW-1:0];
			bns_pkg::ST_SUP_UNI:  uni_q   <= PW'(best_area_q) + PW'(area_q) - PW'(inter_q);
			bns_pkg::ST_SUP_PLO:  plo_q   <= mul_p;
			bns_pkg::ST_SUP_PHI:  phi_q   <= mul_p;
			default: begin
			end
		endcase
		if (emit) begin
			result.kept_x         <= pend_q.x;
			result.kept_y         <= pend_q.y;
			result.kept_width     <= pend_q.w;
			result.kept_height    <= pend_q.h;
			result.is_last_kept   <= emit_last;
			result.set_overflowed <= ovf_q;
		end
	end

endmodule

/* dv/box_nonmax_suppression_test.sv */
// Self-checking testbench for box_nonmax_suppression: loads box sets, predicts
// the surviving boxes of greedy area-ordered IoU suppression, and compares.
// Depends on bns_pkg and the box_nonmax_suppression RTL.
class kept_box_board;
	bns_pkg::box_out_t pending_q[$];
	bns_pkg::rect_t    set_q[$];
	bit                set_overflow;
	logic [16:0]       overlap_limit;
	int                mismatches;

	function new();
		overlap_limit = bns_pkg::LIMIT_RESET;
		mismatches = 0;
		set_overflow = 0;
	endfunction

	function longint unsigned span(longint unsigned a0, longint unsigned al,
			longint unsigned b0, longint unsigned bl);
		longint unsigned lo, hi;
		lo = a0 > b0 ? a0 : b0;
		hi = (a0 + al) < (b0 + bl) ? (a0 + al) : (b0 + bl);
		return hi > lo ? hi - lo : 0;
	endfunction

	function bit dropped_by(bns_pkg::rect_t a, bns_pkg::rect_t b);
		longint unsigned inter, uni;
		inter = span(a.x, a.w, b.x, b.w) * span(a.y, a.h, b.y, b.h);
		uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
		if (uni == 0)
			return 1;
		return (inter << 16) >= longint'(overlap_limit) * uni;
	endfunction

	function void note_box(bns_pkg::box_in_t b);
		bns_pkg::rect_t r, ordered[$];
		bit live[$];
		bns_pkg::box_out_t o;
		int k;
		if (set_q.size() < 64) begin
			r = '{b.box_x, b.box_y, b.box_width, b.box_height};
			set_q.insert(set_q.size(), r);
		end else begin
			set_overflow = 1;
		end
		if (!b.is_last_box)
			return;
		foreach (set_q[i]) begin
			k = ordered.size();
			while (k > 0 && longint'(ordered[k-1].w) * ordered[k-1].h <
					longint'(set_q[i].w) * set_q[i].h)
				k--;
			ordered.insert(k, set_q[i]);
			live.insert(live.size(), 1'b1);
		end
		foreach (ordered[i]) begin
			if (!live[i])
				continue;
			for (int j = i + 1; j < ordered.size(); j++)
				if (live[j] && dropped_by(ordered[i], ordered[j]))
					live[j] = 0;
			o = '{ordered[i].x, ordered[i].y, ordered[i].w, ordered[i].h, 1'b0,
				set_overflow};
			pending_q.insert(pending_q.size(), o);
		end
		pending_q[pending_q.size()-1].is_last_kept = 1;
		set_q.delete();
		set_overflow = 0;
	endfunction

	function void check_kept(bns_pkg::box_out_t got);
		bns_pkg::box_out_t want;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", got);
			return;
		end
		want = pending_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %h actual %h", want, got);
		end
	endfunction
endclass

module box_nonmax_suppression_test;

	logic clk, arst_n, start, busy, result_valid;
	bns_pkg::box_in_t box_in;
	bns_pkg::box_out_t result;
	logic psel, penable, pwrite, pready;
	logic [bns_pkg::APB_AW-1:0] paddr;
	logic [bns_pkg::APB_DW-1:0] pwdata, prdata;
	kept_box_board board;
	int send_idle_pct;
	longint cycles = 0;

	box_nonmax_suppression dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (result_valid)
			board.check_kept(result);
		if (cycles > 3000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_limit(logic [16:0] v);
		psel = 1; pwrite = 1; penable = 0;
		paddr = bns_pkg::APB_AW'(4 * bns_pkg::REG_OVERLAP_LIMIT);
		pwdata = bns_pkg::APB_DW'(v);
		@(negedge clk) penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk) psel = 0; penable = 0; pwrite = 0;
		board.overlap_limit = v;
	endtask

	task automatic drain();
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (60000) @(negedge clk);
	endtask

	task automatic send_box(bns_pkg::box_in_t b);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		start = 1; box_in = b;
		do @(posedge clk); while (busy);
		board.note_box(b);
		@(negedge clk) start = 0;
	endtask

	function automatic bns_pkg::box_in_t pick_box(bit last, int maxsz);
		bns_pkg::box_in_t b;
		b.box_x = bns_pkg::COORD_BITS'($urandom_range(maxsz == 4095 ? 4095 : 200));
		b.box_y = bns_pkg::COORD_BITS'($urandom_range(maxsz == 4095 ? 4095 : 200));
		b.box_width = bns_pkg::COORD_BITS'($urandom_range(maxsz));
		b.box_height = bns_pkg::COORD_BITS'($urandom_range(maxsz));
		b.is_last_box = last;
		return b;
	endfunction

	task automatic send_cluster(int n);
		bns_pkg::box_in_t b, base;
		base = pick_box(0, 60);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				b = pick_box(0, 4095);
			else begin
				b = base;
				b.box_x = bns_pkg::COORD_BITS'(base.box_x + $urandom_range(12));
				b.box_y = bns_pkg::COORD_BITS'(base.box_y + $urandom_range(12));
				b.box_width = bns_pkg::COORD_BITS'(base.box_width + $urandom_range(8));
				b.box_height = bns_pkg::COORD_BITS'(base.box_height + $urandom_range(8));
			end
			b.is_last_box = (i == n - 1);
			send_box(b);
		end
	endtask

	initial begin
		logic [16:0] limits[6] = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd65535, 17'd80000};
		bns_pkg::box_in_t b;
		int sent;
		int n;
		board = new();
		arst_n = 0; start = 0; box_in = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		send_idle_pct = 9;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_box('{12'd0, 12'd0, 12'd0, 12'd0, 1'b1});
		send_box('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0});
		send_box('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0});
		send_box('{12'd0, 12'd0, 12'd4095, 12'd4095, 1'b0});
		send_box('{12'd0, 12'd0, 12'd0, 12'd5, 1'b0});
		send_box('{12'd3, 12'd3, 12'd0, 12'd0, 1'b0});
		send_box('{12'd100, 12'd100, 12'd10, 12'd10, 1'b0});
		send_box('{12'd110, 12'd100, 12'd10, 12'd10, 1'b0});
		send_box('{12'd105, 12'd100, 12'd10, 12'd10, 1'b0});
		send_box('{12'd2730, 12'd1365, 12'd1365, 12'd2730, 1'b1});
		drain();
		write_limit(17'd65536);
		send_box('{12'd5, 12'd5, 12'd8, 12'd8, 1'b0});
		send_box('{12'd5, 12'd5, 12'd8, 12'd8, 1'b0});
		send_box('{12'd0, 12'd0, 12'd0, 12'd0, 1'b0});
		send_box('{12'd0, 12'd0, 12'd0, 12'd0, 1'b1});
		drain();
		write_limit(17'd80000);
		for (int i = 0; i < 66; i++) begin
			b = pick_box(i == 65, 30);
			send_box(b);
		end
		drain();

		sent = 80;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 9 : (ph == 1 ? 76 : 0);
			for (int s = 0; s < 2; s++) begin
				write_limit(limits[ph * 2 + s]);
				repeat (7) begin
					if ($urandom_range(5) == 0) begin
						for (int i = 0; i < 3; i++) begin
							b = pick_box(i == 2, 4095);
							send_box(b);
						end
						sent += 3;
					end else begin
						n = $urandom_range(1, 8);
						send_cluster(n);
						sent += n;
					end
				end
				drain();
			end
		end
		write_limit(bns_pkg::LIMIT_RESET);
		while (sent < 260) begin
			n = $urandom_range(1, 10);
			send_cluster(n);
			sent += n;
		end
		drain();
		if (board.mismatches == 0 && board.pending_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* filelist.f */
rtl/bns_pkg.sv
rtl/bns_cfg_regs.sv
rtl/box_nonmax_suppression.sv
dv/box_nonmax_suppression_test.sv
